>>> rtl/urgency_priority_queue_assert.svh
// Assertion macros used by upq_dp.sv.
`ifndef URGENCY_PRIORITY_QUEUE_ASSERT_SVH
`define URGENCY_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define UPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UPQ_ASSERT(lbl, prop, msg)
`define UPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/upq_pkg.sv
package upq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OCC_W         = 5;

  localparam logic [1:0] TYPE_MSG = 2'd0;
  localparam logic [1:0] TYPE_SYS = 2'd1;
  localparam logic [1:0] TYPE_APP = 2'd2;

  localparam logic [1:0] RANK_MSG  = 2'd3;
  localparam logic [1:0] RANK_SYS  = 2'd2;
  localparam logic [1:0] RANK_APP  = 2'd1;
  localparam logic [1:0] RANK_NONE = 2'd0;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  note_type;
    logic        urgent;
    logic [31:0] timestamp;
    logic [15:0] payload;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [1:0]       out_type;
    logic             out_urgent;
    logic [31:0]      out_timestamp;
    logic [15:0]      out_payload;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  note_type;
    logic        urgent;
    logic [31:0] timestamp;
    logic [15:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_START,
    S_SHIFT,
    S_SHIFT_END,
    S_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start_scan;
    logic start_shift;
    logic issue;
    logic shifting;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic empty;
    logic idx_last;
    logic shift_none;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] rank_of(input logic [1:0] t);
    logic [1:0] r;
    case (t)
      TYPE_MSG: r = RANK_MSG;
      TYPE_SYS: r = RANK_SYS;
      TYPE_APP: r = RANK_APP;
      default:  r = RANK_NONE;
    endcase
    return r;
  endfunction

  // true when a is more urgent than b
  function automatic logic beats(input entry_t a, input entry_t b);
    logic ua;
    logic ub;
    logic w;
    ua = (a.note_type == TYPE_SYS) && a.urgent;
    ub = (b.note_type == TYPE_SYS) && b.urgent;
    if (ua != ub) begin
      w = ua;
    end else if (a.timestamp != b.timestamp) begin
      w = a.timestamp < b.timestamp;
    end else if (ua) begin
      w = 1'b0;
    end else begin
      w = rank_of(a.note_type) > rank_of(b.note_type);
    end
    return w;
  endfunction

endpackage

>>> rtl/upq_ctrl.sv
module upq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  upq_pkg::sts_t sts,
  output upq_pkg::cmd_t cmd
);
  import upq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_pop && !sts.empty) begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.idx_last) begin
          state_next = S_SCAN_END;
        end
      end
      // last read word is compared here
      S_SCAN_END: begin
        state_next = S_SHIFT_START;
      end
      S_SHIFT_START: begin
        cmd.start_shift = 1'b1;
        state_next      = sts.shift_none ? S_FINISH : S_SHIFT;
      end
      S_SHIFT: begin
        cmd.issue    = 1'b1;
        cmd.shifting = 1'b1;
        if (sts.idx_last) begin
          state_next = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        cmd.shifting = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/upq_dp.sv
`include "urgency_priority_queue_assert.svh"

module upq_dp #(
  parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  upq_pkg::req_t req,
  input  upq_pkg::cmd_t cmd,
  output upq_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output upq_pkg::rsp_t rsp
);
  import upq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  entry_t          rd_data;
  logic            rd_vld;
  logic [AW-1:0]   rd_idx;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  logic [AW-1:0]   best_idx;
  entry_t          best;
  req_t            op;
  rsp_t            rsp_next;
  logic [CW+OCC_W-1:0] occ_ext;

  logic            full;
  logic            empty;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);

  // one write port: compaction moves, or the push at the end of an item
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx - AW'(1);
    wr_data = rd_data;
    if (rd_vld && cmd.shifting) begin
      wr_en = 1'b1;
    end else if (cmd.finish && op.kind == KIND_PUSH && !full) begin
      wr_en             = 1'b1;
      wr_addr           = cnt[AW-1:0];
      wr_data.note_type = op.note_type;
      wr_data.urgent    = op.urgent;
      wr_data.timestamp = op.timestamp;
      wr_data.payload   = op.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_comb begin
    cnt_next               = cnt;
    rsp_next.status        = ST_OK;
    rsp_next.out_type      = '0;
    rsp_next.out_urgent    = 1'b0;
    rsp_next.out_timestamp = '0;
    rsp_next.out_payload   = '0;
    if (cmd.finish) begin
      if (op.kind == KIND_PUSH) begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end else if (empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        cnt_next               = cnt - CW'(1);
        rsp_next.out_type      = best.note_type;
        rsp_next.out_urgent    = best.urgent;
        rsp_next.out_timestamp = best.timestamp;
        rsp_next.out_payload   = best.payload;
      end
    end
    occ_ext            = (CW + OCC_W)'(cnt_next);
    rsp_next.occupancy = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      cnt    <= cnt_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
    if (cmd.start_scan) begin
      idx <= '0;
    end else if (cmd.start_shift) begin
      idx <= CW'(best_idx) + CW'(1);
    end else if (cmd.issue) begin
      idx <= idx + CW'(1);
    end
    if (cmd.issue) begin
      rd_idx <= idx[AW-1:0];
    end
    // slot 0 seeds the running best; later slots replace it only when strictly better
    if (rd_vld && !cmd.shifting && (rd_idx == '0 || beats(rd_data, best))) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

  assign sts.is_pop     = (op.kind == KIND_POP);
  assign sts.empty      = empty;
  assign sts.idx_last   = ((idx + CW'(1)) == cnt);
  assign sts.shift_none = ((CW'(best_idx) + CW'(1)) == cnt);
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  `UPQ_ASSERT(a_cnt_bound, cnt <= CW'(DEPTH), "entry count above depth")
  `UPQ_ASSERT(a_read_in_range, cmd.issue |-> idx < cnt, "read beyond held entries")
  `UPQ_ASSERT(a_pop_decrements, (cmd.finish && op.kind == KIND_POP && !empty) |=> cnt == $past(cnt) - CW'(1), "pop did not drop count")
  `UPQ_ASSERT_ALWAYS(a_reset_clears_rsp, rst |=> !rsp_valid, "result valid after reset")

endmodule

>>> rtl/urgency_priority_queue.sv
// Channel  Handshake              Payload         Role
// request  req_valid / req_stall  req  (req_t)    push or pop item
// result   rsp_valid / rsp_stall  rsp  (rsp_t)    one result per item
//
// Push, full push and empty pop: S_IDLE accepts, S_DECODE, and S_FINISH registers the result.
// Pop: one read per slot in S_SCAN finds the winner, then S_SCAN_END and S_SHIFT_START;
// unless the winner is in the last slot, one read per later slot in S_SHIFT closes the gap.
// Reset (rst, synchronous) empties the queue; memory contents are not cleared.
// A new item is taken while an earlier result waits under rsp_stall;
// it completes once the result register is free.
module urgency_priority_queue #(
  parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  upq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output upq_pkg::rsp_t rsp
);
  import upq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  upq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  upq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
